// ----- design/rmt_pkg.sv -----
`default_nettype none
package rmt_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int MAX_SAMPLES_DEF = 256;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // chain operation for one transfer
   localparam logic [1:0] OP_HOLD   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;  // sorted insert of sample
   localparam logic [1:0] OP_PUSH   = 2'd2;  // push push_value at head
   localparam logic [1:0] OP_POPINS = 2'd3;  // drop head, sorted insert of sample

   typedef struct packed {
      logic       en;
      logic [1:0] op;
      sample_type sample;
      sample_type push_value;
   } ctrl_type;

endpackage
`default_nettype wire

// ----- design/rmt_cell.sv -----
`default_nettype none
module rmt_cell #(
   parameter int IDX     = 0,
   parameter int CNT_W   = 1,
   parameter bit DESCEND = 1'b0
) (
   input  wire logic              clock,
   input  wire rmt_pkg::ctrl_type ctrl,
   input  wire logic [CNT_W-1:0]  count,
   input  wire rmt_pkg::sample_type prev_value,
   input  wire logic              prev_beats,
   input  wire rmt_pkg::sample_type next_value,
   input  wire logic              next_beats,
   output rmt_pkg::sample_type    value,
   output rmt_pkg::sample_type    value_in,
   output logic                   beats
);
   import rmt_pkg::*;

   sample_type value_ff;
   logic       valid;
   logic       cmp;

   assign valid = CNT_W'(IDX) < count;
   assign cmp   = DESCEND ? ($signed(ctrl.sample) > $signed(value_ff))
                          : ($signed(ctrl.sample) < $signed(value_ff));
   // sample sorts ahead of this entry (empty entries always lose)
   assign beats = !valid || cmp;
   assign value = value_ff;

   always_comb begin
      case (ctrl.op)
         OP_INSERT: value_in = prev_beats ? prev_value : (beats ? ctrl.sample : value_ff);
         OP_PUSH:   value_in = prev_value;
         // head never beaten here, so the chain shifts toward the head
         OP_POPINS: value_in = beats ? value_ff : (next_beats ? ctrl.sample : next_value);
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         value_ff <= value_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/rmt_chain.sv -----
`default_nettype none
module rmt_chain #(
   parameter int DEPTH   = 128,
   parameter bit DESCEND = 1'b0,
   parameter int CNT_W   = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire rmt_pkg::ctrl_type ctrl,
   output rmt_pkg::sample_type   head,
   output rmt_pkg::sample_type   head_in,
   output logic [CNT_W-1:0]      count
);
   import rmt_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_eff;
   logic             grow;

   sample_type val    [DEPTH];
   sample_type val_in [DEPTH];
   logic       beats  [DEPTH];

   assign count_eff = clear ? '0 : count_ff;
   assign grow      = (ctrl.op == OP_INSERT) || (ctrl.op == OP_PUSH);
   assign count_in  = count_eff + CNT_W'(grow);
   assign count     = count_eff;
   assign head      = val[0];
   assign head_in   = val_in[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.en) begin
         count_ff <= count_in;
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         sample_type pv;
         logic       pb;
         sample_type nv;
         logic       nb;

         if (i == 0) begin : g_first
            assign pv = ctrl.push_value;
            assign pb = 1'b0;
         end else begin : g_mid
            assign pv = val[i-1];
            assign pb = beats[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign nv = val[i];
            assign nb = 1'b1;
         end else begin : g_inner
            assign nv = val[i+1];
            assign nb = beats[i+1];
         end

         rmt_cell #(
            .IDX     (i),
            .CNT_W   (CNT_W),
            .DESCEND (DESCEND)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .count      (count_eff),
            .prev_value (pv),
            .prev_beats (pb),
            .next_value (nv),
            .next_beats (nb),
            .value      (val[i]),
            .value_in   (val_in[i]),
            .beats      (beats[i])
         );
      end
   endgenerate

endmodule
`default_nettype wire

// ----- design/running_median_tracker_top.sv -----
`default_nettype none
// Result strobe is registered: it rises in the cycle after the transfer on start.
// Throughput: one sample per clock; busy is never raised, and the receiver cannot stall.
// Lower half sits in a descending cell chain, upper half in an ascending one; both
// chains compare and shift in parallel, and the median is always the lower chain's head.
// Reset: clears both fill counts and the held median to zero; no clearing pass.
module running_median_tracker_top #(
   parameter int MAX_SAMPLES = rmt_pkg::MAX_SAMPLES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire rmt_pkg::sample_type req_sample,
   input  wire logic          req_restart,
   output logic               rsp_strobe,
   output rmt_pkg::sample_type rsp_median,
   output logic               rsp_overflow
);
   import rmt_pkg::*;

   localparam int DEPTH_L = (MAX_SAMPLES + 1) / 2;
   localparam int DEPTH_U = MAX_SAMPLES / 2;
   localparam int CW      = $clog2(MAX_SAMPLES + 1);
   localparam int CW_L    = $clog2(DEPTH_L + 1);
   localparam int CW_U    = $clog2(DEPTH_U + 1);

   logic             accept;
   logic             clear;
   logic             full;
   logic             odd;
   logic             go_low;
   logic             go_up;
   logic [CW_L-1:0]  cnt_l;
   logic [CW_U-1:0]  cnt_u;
   sample_type       head_l;
   sample_type       head_l_in;
   sample_type       head_u;
   sample_type       head_u_in;
   ctrl_type         ctrl_l;
   ctrl_type         ctrl_u;

   logic             rsp_strobe_ff;
   sample_type       rsp_median_ff;
   logic             rsp_overflow_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign clear  = accept && req_restart;

   // counts already reflect a restart on this transfer
   assign full   = (cnt_l == CW_L'(DEPTH_L)) && (cnt_u == CW_U'(DEPTH_U));
   assign odd    = CW'(cnt_l) != CW'(cnt_u);
   assign go_low = (cnt_u == '0) || ($signed(req_sample) <= $signed(head_u));
   assign go_up  = $signed(req_sample) >= $signed(head_l);

   always_comb begin
      ctrl_l.en         = accept && !full;
      ctrl_l.sample     = req_sample;
      ctrl_l.push_value = head_u;
      ctrl_u.en         = accept && !full;
      ctrl_u.sample     = req_sample;
      ctrl_u.push_value = head_l;
      if (!odd) begin
         // lower half grows: sample itself or the upper head moves down
         ctrl_l.op = go_low ? OP_INSERT : OP_PUSH;
         ctrl_u.op = go_low ? OP_HOLD : OP_POPINS;
      end else begin
         // upper half grows: sample itself or the lower head moves up
         ctrl_u.op = go_up ? OP_INSERT : OP_PUSH;
         ctrl_l.op = go_up ? OP_HOLD : OP_POPINS;
      end
   end

   rmt_chain #(
      .DEPTH   (DEPTH_L),
      .DESCEND (1'b1),
      .CNT_W   (CW_L)
   ) u_low (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .ctrl    (ctrl_l),
      .head    (head_l),
      .head_in (head_l_in),
      .count   (cnt_l)
   );

   rmt_chain #(
      .DEPTH   (DEPTH_U),
      .DESCEND (1'b0),
      .CNT_W   (CW_U)
   ) u_up (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .ctrl    (ctrl_u),
      .head    (head_u),
      .head_in (head_u_in),
      .count   (cnt_u)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         rsp_median_ff <= '0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept && !full) begin
            rsp_median_ff <= head_l_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_overflow_ff <= full;
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_median   = rsp_median_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // next upper head is not needed; the median comes from the lower chain
   logic unused_head_u_in;
   assign unused_head_u_in = ^head_u_in;

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("result strobe missing after transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result strobe without transfer");

   a_balanced: assert property (@(posedge clock) disable iff (reset)
      (CW'(u_low.count_ff) == CW'(u_up.count_ff)) ||
      (CW'(u_low.count_ff) == CW'(u_up.count_ff) + CW'(1)))
      else $error("halves out of balance");

   a_overflow_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_overflow) |-> $stable(rsp_median))
      else $error("median changed on dropped sample");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_SAMPLES   = rmt_pkg::MAX_SAMPLES_DEF;
   localparam int ITEM_TARGET   = 850;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      rmt_pkg::sample_type median;
      logic                overflow;
   } median_result_type;

   class median_scoreboard_type;
      rmt_pkg::sample_type held[$];
      rmt_pkg::sample_type last_median;
      median_result_type   awaited[$];
      int unsigned         max_held;
      int unsigned         errors;
      int unsigned         checked;

      function new(int unsigned depth);
         max_held    = depth;
         last_median = '0;
         errors      = 0;
         checked     = 0;
      endfunction

      // predict the median for one accepted sample
      function void note_transfer(rmt_pkg::sample_type value, logic restart);
         median_result_type r;
         int unsigned       pos;
         if (restart) begin
            held.delete();
         end
         r.overflow = 1'b0;
         if (held.size() >= max_held) begin
            r.overflow = 1'b1;
         end else begin
            // equal values go after existing ones
            pos = held.size();
            while (pos > 0 && held[pos-1] > value) begin
               pos--;
            end
            held.insert(pos, value);
            last_median = held[(held.size() - 1) / 2];
         end
         r.median = last_median;
         awaited.push_back(r);
      endfunction

      function void check_result(rmt_pkg::sample_type median, logic overflow);
         median_result_type r;
         checked++;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("result %0d: unexpected, median %0d overflow %0b",
                        checked, median, overflow);
            end
         end else begin
            r = awaited.pop_front();
            if (median !== r.median || overflow !== r.overflow) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("result %0d: median exp %0d got %0d, overflow exp %0b got %0b",
                           checked, r.median, median, r.overflow, overflow);
               end
            end
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   rmt_pkg::sample_type req_sample;
   logic                req_restart;
   logic                rsp_strobe;
   rmt_pkg::sample_type rsp_median;
   logic                rsp_overflow;

   median_scoreboard_type sb;
   int unsigned           items_sent;
   int unsigned           stall_count;

   running_median_tracker_top #(.MAX_SAMPLES(MAX_SAMPLES)) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_sample   (req_sample),
      .req_restart  (req_restart),
      .rsp_strobe   (rsp_strobe),
      .rsp_median   (rsp_median),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // results first: the one strobed now belongs to an earlier transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            sb.check_result(rsp_median, rsp_overflow);
         end
         if (start && !busy) begin
            sb.note_transfer(req_sample, req_restart);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // called right after a rising edge; returns at the edge of the transfer
   task automatic send_sample(rmt_pkg::sample_type value, logic restart);
      @(negedge clock);
      start       <= 1'b1;
      req_sample  <= value;
      req_restart <= restart;
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
      items_sent++;
   endtask

   task automatic idle_cycles(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic random_gap();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick >= 18) begin
         idle_cycles($urandom_range(8, 40));
      end else if (pick >= 12) begin
         idle_cycles($urandom_range(1, 3));
      end
   endtask

   function automatic rmt_pkg::sample_type pick_sample();
      rmt_pkg::sample_type v;
      case ($urandom_range(0, 9))
         0:       v = 16'sh8000;
         1:       v = 16'sh7fff;
         2, 3:    v = rmt_pkg::sample_type'($signed($urandom_range(0, 8)) - 4);
         default: v = rmt_pkg::sample_type'($urandom);
      endcase
      return v;
   endfunction

   initial begin
      int unsigned seq_len;
      int unsigned k;
      bit          gaps_on;
      logic        rst;

      sb          = new(MAX_SAMPLES);
      items_sent  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_sample  = '0;
      req_restart = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first sample without restart, extremes, duplicates, odd/even counts
      send_sample(16'sh1234, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh0000, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'shffff, 1'b0);
      idle_cycles(2);
      send_sample(16'sh0005, 1'b1);
      send_sample(16'sh0005, 1'b0);
      send_sample(16'sh0005, 1'b0);
      send_sample(16'sh0003, 1'b0);
      send_sample(16'sh0005, 1'b0);
      send_sample(16'sh0007, 1'b0);
      send_sample(16'sh0003, 1'b0);
      send_sample(16'shffff, 1'b1);
      send_sample(16'sh0001, 1'b0);
      send_sample(16'sh5555, 1'b1);
      send_sample(16'shaaaa, 1'b0);
      send_sample(16'sh7fff, 1'b0);
      send_sample(16'sh8000, 1'b0);
      wait_drained();

      // fill the store past its depth, then restart while full
      send_sample(pick_sample(), 1'b1);
      for (k = 1; k < MAX_SAMPLES + 6; k++) begin
         send_sample(pick_sample(), 1'b0);
         if ($urandom_range(0, 7) == 0) random_gap();
      end
      send_sample(pick_sample(), 1'b1);

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0:                      seq_len = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 20);
            1, 2, 3:                seq_len = $urandom_range(31, 120);
            default:                seq_len = $urandom_range(1, 30);
         endcase
         gaps_on = ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) == 0) wait_drained();
         for (k = 0; k < seq_len && items_sent < ITEM_TARGET; k++) begin
            // mostly a restart heads each run; a few runs continue or break early
            if (k == 0) rst = ($urandom_range(0, 9) != 0);
            else        rst = ($urandom_range(0, 59) == 0);
            send_sample(pick_sample(), rst);
            if (gaps_on) random_gap();
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- running_median_tracker_top.f -----
design/rmt_pkg.sv
design/rmt_cell.sv
design/rmt_chain.sv
design/running_median_tracker_top.sv
tb/testbench.sv
